### rtl/core/xtea_pkg.sv
// Shared types, constants and the mixing function for the XTEA encipher core.
// No dependencies; imported by every module of the core.
package xtea_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 3;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  localparam logic [IDX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ROUNDS = 3'd4;

  localparam logic [CNT_W-1:0] ROUNDS_RESET = 7'd32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  function automatic word_t xtea_mix(input word_t x);
    xtea_mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

### rtl/core/xtea_ctrl.sv
// Controller for the XTEA encipher core: state, round counter and output valid.
// Depends on xtea_pkg; drives the datapath through ctrl_cmd_t.
module xtea_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  logic [xtea_pkg::CNT_W-1:0] round_count,
  output xtea_pkg::ctrl_cmd_t       cmd
);
  import xtea_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == round_count) begin
          if (out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/xtea_dpath.sv
// Datapath for the XTEA encipher core: block halves, running sum and output registers.
// Depends on xtea_pkg; commanded by xtea_ctrl.
module xtea_dpath (
  input  logic                clk,
  input  xtea_pkg::ctrl_cmd_t cmd,
  input  xtea_pkg::key_t      key,
  input  xtea_pkg::word_t     plain_first,
  input  xtea_pkg::word_t     plain_second,
  output xtea_pkg::word_t     cipher_first,
  output xtea_pkg::word_t     cipher_second
);
  import xtea_pkg::*;

  word_t a_r, b_r, sum_r;
  word_t out_a_r, out_b_r;
  word_t sum_step, a_step, b_step;

  assign sum_step = sum_r + XTEA_DELTA;
  assign a_step   = a_r + (xtea_mix(b_r) ^ (sum_r + key[sum_r[1:0]]));
  assign b_step   = b_r + (xtea_mix(a_step) ^ (sum_step + key[sum_step[12:11]]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= plain_first;
      b_r   <= plain_second;
      sum_r <= '0;
    end else if (cmd.step) begin
      a_r   <= a_step;
      b_r   <= b_step;
      sum_r <= sum_step;
    end
    if (cmd.commit) begin
      out_a_r <= a_r;
      out_b_r <= b_r;
    end
  end

  assign cipher_first  = out_a_r;
  assign cipher_second = out_b_r;

endmodule

### rtl/core/xtea_block_encipher_core.sv
// XTEA encipher core: one round of both half-updates per clock.
// A block runs round_count rounds, then commits to the output register,
// waiting while an earlier result stalls. One block is in flight at a time,
// set by the single shared round unit; a finished block waits in the output
// register while the next is accepted. Synchronous active-low reset clears
// control state, the key to zero and round_count to 32. Depends on xtea_pkg.
module xtea_block_encipher_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  xtea_pkg::word_t             in_plain_first,
  input  xtea_pkg::word_t             in_plain_second,
  output logic                        out_valid,
  input  logic                        out_ready,
  output xtea_pkg::word_t             out_cipher_first,
  output xtea_pkg::word_t             out_cipher_second,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [xtea_pkg::IDX_W-1:0]  cfg_index,
  input  xtea_pkg::word_t             cfg_data
);
  import xtea_pkg::*;

  key_t             key_r;
  logic [CNT_W-1:0] rounds_r;
  ctrl_cmd_t        cmd;
  logic             cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= ROUNDS_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_KEY0:   key_r[0] <= cfg_data;
        CFG_KEY1:   key_r[1] <= cfg_data;
        CFG_KEY2:   key_r[2] <= cfg_data;
        CFG_KEY3:   key_r[3] <= cfg_data;
        CFG_ROUNDS: rounds_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  xtea_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .round_count (rounds_r),
    .cmd         (cmd)
  );

  xtea_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .key           (key_r),
    .plain_first   (in_plain_first),
    .plain_second  (in_plain_second),
    .cipher_first  (out_cipher_first),
    .cipher_second (out_cipher_second)
  );

endmodule

### rtl/core/xtea_checker.sv
// Port-level checker for the XTEA encipher core, bound to the top level.
// Depends on xtea_pkg for field widths.
module xtea_core_assert (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input xtea_pkg::word_t            out_cipher_first,
  input xtea_pkg::word_t            out_cipher_second,
  input logic                       cfg_ready
);
  import xtea_pkg::*;

  // A stalled result keeps its valid high.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cipher_first) && $stable(out_cipher_second))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An accepted block occupies the round unit, so in_ready falls after the accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // The register port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind xtea_block_encipher_core xtea_core_assert u_xtea_core_assert (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_cipher_first  (out_cipher_first),
  .out_cipher_second (out_cipher_second),
  .cfg_ready         (cfg_ready)
);
